// ===== rtl/core/lesf_pkg.sv =====
// Shared types and register codes for the largest empty square finder.
package lesf_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 1;

    // Configuration register indices.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_reg_t;

    // Position flags that travel with a cell from the scan stage to the size stage.
    typedef struct packed {
        logic empty;
        logic first_row;
        logic first_col;
        logic last_cell;
    } cell_flags_t;

endpackage

// ===== rtl/core/lesf_line_buf.sv =====
// Line buffer of the previous row's square sizes, with same-entry write forwarding.
module lesf_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 11
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written in the same cycle returns the new value.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== rtl/core/lesf_scan_ctrl.sv =====
// Configuration registers, raster position counters and the cell acceptance stage.
module lesf_scan_ctrl
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int ROW_BITS = 16,
    parameter int SIZE_W   = 11,
    parameter int COL_W    = 10,
    parameter int CFG_W    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cell_empty,
    input  logic                 result_busy,
    output logic                 rd_en,
    output logic [COL_W-1:0]     rd_addr,
    output logic                 s1_valid,
    output cell_flags_t          s1_flags,
    output logic [ROW_BITS-1:0]  s1_row,
    output logic [COL_W-1:0]     s1_col
);

    logic [ROW_BITS-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0]    last_col_reg, last_col_next;
    logic [ROW_BITS-1:0] row_index_reg, row_index_next;
    logic [COL_W-1:0]    col_index_reg, col_index_next;
    logic                s1_valid_reg;
    cell_flags_t         s1_flags_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_BITS-1:0] row_value;
    logic [SIZE_W-1:0]   col_value;
    logic                at_last_col;
    logic                at_last_row;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign row_value = cfg_data[ROW_BITS-1:0];
    assign col_value = cfg_data[SIZE_W-1:0];

    // Registers are kept as the index of the last row and column; zero counts as one
    // and a column count beyond the buffer depth saturates.
    always_comb begin
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROW_COUNT: begin
                    last_row_next = (row_value == '0) ? '0 : row_value - ROW_BITS'(1);
                end
                REG_COL_COUNT: begin
                    if (col_value == '0) begin
                        last_col_next = '0;
                    end else if (col_value > SIZE_W'(MAX_COLS)) begin
                        last_col_next = COL_W'(MAX_COLS - 1);
                    end else begin
                        last_col_next = COL_W'(col_value - SIZE_W'(1));
                    end
                end
                default: begin
                    last_row_next = last_row_reg;
                end
            endcase
        end
    end

    assign at_last_col = (col_index_reg >= last_col_reg);
    assign at_last_row = (row_index_reg >= last_row_reg);
    assign s_ready     = !(at_last_col && at_last_row && result_busy);
    assign accept      = s_valid && s_ready;

    always_comb begin
        row_index_next = row_index_reg;
        col_index_next = col_index_reg;
        if (accept) begin
            if (!at_last_col) begin
                col_index_next = col_index_reg + COL_W'(1);
            end else if (!at_last_row) begin
                col_index_next = '0;
                row_index_next = row_index_reg + ROW_BITS'(1);
            end else begin
                col_index_next = '0;
                row_index_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_row_reg  <= '0;
            last_col_reg  <= '0;
            row_index_reg <= '0;
            col_index_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            last_row_reg  <= last_row_next;
            last_col_reg  <= last_col_next;
            row_index_reg <= row_index_next;
            col_index_reg <= col_index_next;
            s1_valid_reg  <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_flags_reg.empty     <= s_cell_empty;
            s1_flags_reg.first_row <= (row_index_reg == '0);
            s1_flags_reg.first_col <= (col_index_reg == '0);
            s1_flags_reg.last_cell <= at_last_col && at_last_row;
            s1_row_reg             <= row_index_reg;
            s1_col_reg             <= col_index_reg;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = col_index_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_flags = s1_flags_reg;
    assign s1_row   = s1_row_reg;
    assign s1_col   = s1_col_reg;

endmodule

// ===== rtl/core/lesf_square_core.sv =====
// Square size update for one cell, line buffer write-back and best square tracking.
module lesf_square_core
    import lesf_pkg::*;
#(
    parameter int ROW_BITS = 16,
    parameter int SIZE_W   = 11,
    parameter int COL_W    = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s1_valid,
    input  cell_flags_t         s1_flags,
    input  logic [ROW_BITS-1:0] s1_row,
    input  logic [COL_W-1:0]    s1_col,
    input  logic [SIZE_W-1:0]   up_raw,
    output logic                wr_en,
    output logic [COL_W-1:0]    wr_addr,
    output logic [SIZE_W-1:0]   wr_data,
    output logic                fin_valid,
    output logic [SIZE_W-1:0]   fin_size,
    output logic [ROW_BITS-1:0] fin_row,
    output logic [COL_W-1:0]    fin_col
);

    logic [SIZE_W-1:0]   left_size_reg;
    logic [SIZE_W-1:0]   diag_size_reg;
    logic [SIZE_W-1:0]   best_size_reg, best_size_next;
    logic [ROW_BITS-1:0] best_row_reg, best_row_next;
    logic [COL_W-1:0]    best_col_reg, best_col_next;
    logic                fin_valid_reg;
    logic [SIZE_W-1:0]   fin_size_reg;
    logic [ROW_BITS-1:0] fin_row_reg;
    logic [COL_W-1:0]    fin_col_reg;
    logic [SIZE_W-1:0]   up;
    logic [SIZE_W-1:0]   left;
    logic [SIZE_W-1:0]   diag;
    logic [SIZE_W-1:0]   min_lu;
    logic [SIZE_W-1:0]   min_all;
    logic [SIZE_W-1:0]   size;
    logic                better;
    logic [SIZE_W-1:0]   cand_size;
    logic [ROW_BITS-1:0] cand_row;
    logic [COL_W-1:0]    cand_col;

    // Neighbours outside the grid count as zero.
    assign up      = s1_flags.first_row ? '0 : up_raw;
    assign left    = s1_flags.first_col ? '0 : left_size_reg;
    assign diag    = (s1_flags.first_row || s1_flags.first_col) ? '0 : diag_size_reg;
    assign min_lu  = (left < up) ? left : up;
    assign min_all = (min_lu < diag) ? min_lu : diag;
    assign size    = s1_flags.empty ? min_all + SIZE_W'(1) : '0;

    assign better    = (size > best_size_reg);
    assign cand_size = better ? size : best_size_reg;
    assign cand_row  = better ? s1_row : best_row_reg;
    assign cand_col  = better ? s1_col : best_col_reg;

    always_comb begin
        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (s1_valid) begin
            if (s1_flags.last_cell) begin
                best_size_next = '0;
                best_row_next  = '0;
                best_col_next  = '0;
            end else begin
                best_size_next = cand_size;
                best_row_next  = cand_row;
                best_col_next  = cand_col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_size_reg <= '0;
            diag_size_reg <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            fin_valid_reg <= 1'b0;
        end else begin
            if (s1_valid) begin
                left_size_reg <= size;
                diag_size_reg <= up;
            end
            best_size_reg <= best_size_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
            fin_valid_reg <= s1_valid && s1_flags.last_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid && s1_flags.last_cell) begin
            fin_size_reg <= cand_size;
            fin_row_reg  <= cand_row;
            fin_col_reg  <= cand_col;
        end
    end

    assign wr_en     = s1_valid;
    assign wr_addr   = s1_col;
    assign wr_data   = size;
    assign fin_valid = fin_valid_reg;
    assign fin_size  = fin_size_reg;
    assign fin_row   = fin_row_reg;
    assign fin_col   = fin_col_reg;

endmodule

// ===== rtl/core/largest_empty_square_finder.sv =====
// A result is offered once the grid's last cell has passed the scan, finish and result registers.
// Throughput: one cell per cycle, bounded by the single read and write port of the
// line buffer; a grid's last cell is held off while an earlier result is in flight.
// Reset (aresetn, synchronous, active low) clears position, best square, the result
// register and sets a 1 x 1 grid; the line buffer is not cleared and needs no sweep.
// Top level of the largest empty square finder.
module largest_empty_square_finder
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int ROW_BITS = 16,
    localparam int SIZE_W  = $clog2(MAX_COLS + 1),
    localparam int COL_W   = $clog2(MAX_COLS),
    localparam int CFG_W   = (ROW_BITS > SIZE_W) ? ROW_BITS : SIZE_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cell_empty,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SIZE_W-1:0]    m_square_size,
    output logic [ROW_BITS-1:0]  m_top_row,
    output logic [COL_W-1:0]     m_left_col
);

    // Width for the corner subtraction, wide enough for either operand.
    localparam int DIFF_W = CFG_W + 1;

    logic                rd_en;
    logic [COL_W-1:0]    rd_addr;
    logic [SIZE_W-1:0]   rd_data;
    logic                s1_valid;
    cell_flags_t         s1_flags;
    logic [ROW_BITS-1:0] s1_row;
    logic [COL_W-1:0]    s1_col;
    logic                wr_en;
    logic [COL_W-1:0]    wr_addr;
    logic [SIZE_W-1:0]   wr_data;
    logic                fin_valid;
    logic [SIZE_W-1:0]   fin_size;
    logic [ROW_BITS-1:0] fin_row;
    logic [COL_W-1:0]    fin_col;
    logic                result_busy;
    logic                m_valid_reg;
    logic [SIZE_W-1:0]   m_square_size_reg;
    logic [ROW_BITS-1:0] m_top_row_reg, m_top_row_next;
    logic [COL_W-1:0]    m_left_col_reg, m_left_col_next;
    logic [DIFF_W-1:0]   size_ext;
    logic [DIFF_W-1:0]   top_diff;
    logic [DIFF_W-1:0]   left_diff;

    // The last cell of a grid may only be taken when nothing else can claim the result
    // register before it: no result waiting, none in the size stage and none finishing.
    assign result_busy = m_valid_reg || (s1_valid && s1_flags.last_cell) || fin_valid;

    lesf_scan_ctrl #(
        .MAX_COLS (MAX_COLS),
        .ROW_BITS (ROW_BITS),
        .SIZE_W   (SIZE_W),
        .COL_W    (COL_W),
        .CFG_W    (CFG_W)
    ) u_scan_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_empty (s_cell_empty),
        .result_busy  (result_busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .s1_valid     (s1_valid),
        .s1_flags     (s1_flags),
        .s1_row       (s1_row),
        .s1_col       (s1_col)
    );

    // The buffer read for a cell is issued on its transfer and lands in the size stage
    // in the cycle after it; a write to the same column in the cycle of the read is forwarded.
    lesf_line_buf #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_W),
        .DATA_W (SIZE_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lesf_square_core #(
        .ROW_BITS (ROW_BITS),
        .SIZE_W   (SIZE_W),
        .COL_W    (COL_W)
    ) u_square_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_valid  (s1_valid),
        .s1_flags  (s1_flags),
        .s1_row    (s1_row),
        .s1_col    (s1_col),
        .up_raw    (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .fin_valid (fin_valid),
        .fin_size  (fin_size),
        .fin_row   (fin_row),
        .fin_col   (fin_col)
    );

    // The best square is tracked by its bottom-right cell; the reported corner is the
    // top-left one. With no empty cell both coordinates read as zero.
    assign size_ext  = DIFF_W'(fin_size);
    assign top_diff  = DIFF_W'(fin_row) - size_ext + DIFF_W'(1);
    assign left_diff = DIFF_W'(fin_col) - size_ext + DIFF_W'(1);

    always_comb begin
        if (fin_size == '0) begin
            m_top_row_next  = '0;
            m_left_col_next = '0;
        end else begin
            m_top_row_next  = top_diff[ROW_BITS-1:0];
            m_left_col_next = left_diff[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_valid) begin
            m_square_size_reg <= fin_size;
            m_top_row_reg     <= m_top_row_next;
            m_left_col_reg    <= m_left_col_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_square_size = m_square_size_reg;
    assign m_top_row     = m_top_row_reg;
    assign m_left_col    = m_left_col_reg;

    // A finished grid never lands on a result that has not yet been transferred.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid |-> !m_valid_reg)
        else $error("result register overwritten before transfer");

    // The last cell of a grid in the size stage always raises the finish register.
    a_last_cell_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && s1_flags.last_cell) |=> fin_valid)
        else $error("last cell of a grid did not finish the grid");

    a_finish_offers_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid |=> m_valid_reg)
        else $error("finished grid did not raise a result");

    // A grid with no empty cell reports a zero corner.
    a_empty_result_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_square_size_reg == '0)) |->
            ((m_top_row_reg == '0) && (m_left_col_reg == '0)))
        else $error("zero-size result carries a non-zero corner");

endmodule
